[sv/ssws_pkg.sv]
// Shared types and constants for the k by k window sum block.
// No dependencies; imported by every other file except ssws_ram.
package ssws_pkg;

   localparam int MAX_SIZE     = 64;
   localparam int MAX_WINDOW   = 8;
   localparam int ELEMENT_BITS = 16;

   // Fixed by the register and result field definitions
   localparam int MATRIX_SIZE_BITS = 7;
   localparam int WINDOW_SIZE_BITS = 4;
   localparam int SUM_BITS         = 22;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 7;

   localparam int SIZE_BITS    = $clog2(MAX_SIZE);
   localparam int N_BITS       = SIZE_BITS + 1;
   localparam int SLOT_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int COL_SUM_BITS = ELEMENT_BITS + SLOT_BITS + 1;

   localparam int MATRIX_SIZE_RESET = 5;
   localparam int WINDOW_SIZE_RESET = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int OUT_DEPTH     = 2;
   localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MATRIX_SIZE = 2'd0,
      CSR_WINDOW_SIZE = 2'd1
   } csr_index_type;

   // One classified element on its way from front to back
   typedef struct packed {
      logic signed [ELEMENT_BITS-1:0] element;
      logic [SIZE_BITS-1:0]           col;
      logic [SLOT_BITS-1:0]           row_slot;
      logic [SLOT_BITS-1:0]           old_slot;
      logic [SLOT_BITS-1:0]           tap_sel;
      logic                           row_zero;
      logic                           row_ge_k;
      logic                           col_zero;
      logic                           col_ge_k;
      logic                           emit;
      logic                           row_done;
      logic                           last;
   } work_item_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] window_sum;
      logic                       row_done;
      logic                       last;
   } rsp_item_type;

endpackage

[sv/ssws_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ssws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ssws_front.sv]
// Front end: configuration registers, row and column counters, item classification.
// Depends on ssws_pkg.
module ssws_front import ssws_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [ELEMENT_BITS-1:0] req_element_value,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]       csr_data,
   input  logic                           q_full,
   output logic                           q_push,
   output work_item_type                  q_item
);

   logic [MATRIX_SIZE_BITS-1:0] n_cfg_ff, n_cfg_in;
   logic [WINDOW_SIZE_BITS-1:0] k_cfg_ff, k_cfg_in;
   logic [SIZE_BITS-1:0]        row_ff, row_in;
   logic [SIZE_BITS-1:0]        col_ff, col_in;
   logic [N_BITS-1:0]           n_eff;
   logic [WINDOW_SIZE_BITS-1:0] k_eff;
   logic [N_BITS-1:0]           k_ext;
   logic [N_BITS-1:0]           row_ext;
   logic [N_BITS-1:0]           col_ext;
   logic                        col_last;
   logic                        row_last;
   logic                        accept;
   logic                        restart;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign q_push    = accept;

   // Clamp geometry into the supported range
   always_comb begin
      if (n_cfg_ff == '0) begin
         n_eff = N_BITS'(1);
      end else if (32'(n_cfg_ff) > MAX_SIZE) begin
         n_eff = N_BITS'(MAX_SIZE);
      end else begin
         n_eff = N_BITS'(n_cfg_ff);
      end
      if (k_cfg_ff == '0) begin
         k_eff = WINDOW_SIZE_BITS'(1);
      end else if (32'(k_cfg_ff) > MAX_WINDOW) begin
         k_eff = WINDOW_SIZE_BITS'(MAX_WINDOW);
      end else begin
         k_eff = k_cfg_ff;
      end
   end

   assign k_ext    = N_BITS'(k_eff);
   assign row_ext  = {1'b0, row_ff};
   assign col_ext  = {1'b0, col_ff};
   assign col_last = (col_ext == n_eff - N_BITS'(1));
   assign row_last = (row_ext == n_eff - N_BITS'(1));

   always_comb begin
      q_item.element  = req_element_value;
      q_item.col      = col_ff;
      q_item.row_slot = row_ff[SLOT_BITS-1:0];
      q_item.old_slot = row_ff[SLOT_BITS-1:0] - k_eff[SLOT_BITS-1:0];
      q_item.tap_sel  = SLOT_BITS'(k_eff - WINDOW_SIZE_BITS'(1));
      q_item.row_zero = (row_ff == '0);
      q_item.row_ge_k = (row_ext >= k_ext);
      q_item.col_zero = (col_ff == '0);
      q_item.col_ge_k = (col_ext >= k_ext);
      q_item.emit     = (k_ext <= n_eff) && (row_ext + N_BITS'(1) >= k_ext)
                        && (col_ext + N_BITS'(1) >= k_ext);
      q_item.row_done = col_last;
      q_item.last     = col_last && row_last;
   end

   // Register writes; either one restarts the matrix
   always_comb begin
      n_cfg_in = n_cfg_ff;
      k_cfg_in = k_cfg_ff;
      restart  = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MATRIX_SIZE: begin
               n_cfg_in = csr_data[MATRIX_SIZE_BITS-1:0];
               restart  = 1'b1;
            end
            CSR_WINDOW_SIZE: begin
               k_cfg_in = csr_data[WINDOW_SIZE_BITS-1:0];
               restart  = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + SIZE_BITS'(1);
         end else begin
            col_in = col_ff + SIZE_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_cfg_ff <= MATRIX_SIZE_BITS'(MATRIX_SIZE_RESET);
         k_cfg_ff <= WINDOW_SIZE_BITS'(WINDOW_SIZE_RESET);
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         n_cfg_ff <= n_cfg_in;
         k_cfg_ff <= k_cfg_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ext < n_eff) else $error("column counter beyond matrix side");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ext < n_eff) else $error("row counter beyond matrix side");

   a_last_ends_row: assert property (@(posedge clock) disable iff (reset)
      (accept && !restart && q_item.last) |=> (row_ff == '0 && col_ff == '0))
      else $error("matrix did not wrap after its final element");

endmodule

[sv/ssws_queue.sv]
// Short queue of classified items between front and back ends.
// Depends on ssws_pkg.
module ssws_queue import ssws_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  work_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output work_item_type head
);

   work_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue read while empty");

endmodule

[sv/ssws_back.sv]
// Back end: column sums over the last k rows, running window sum, result buffer.
// Depends on ssws_pkg and ssws_ram.
module ssws_back import ssws_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  work_item_type              q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SUM_BITS-1:0] rsp_window_sum,
   output logic                       rsp_row_done,
   output logic                       rsp_last
);

   localparam int STORE_DEPTH = MAX_WINDOW * MAX_SIZE;

   work_item_type                  s1_ff;
   logic                           s1_valid_ff;
   logic [COL_SUM_BITS-1:0]        col_sum_rd;
   logic [ELEMENT_BITS-1:0]        row_store_rd;
   logic signed [COL_SUM_BITS-1:0] x_ext;
   logic signed [COL_SUM_BITS-1:0] old_ext;
   logic signed [COL_SUM_BITS-1:0] col_sum_new;
   logic signed [COL_SUM_BITS-1:0] tap_ff [MAX_WINDOW];
   logic signed [SUM_BITS-1:0]     run_ff, run_in;
   logic signed [SUM_BITS-1:0]     leaving;
   logic                           s1_push;

   rsp_item_type                   out_ff [OUT_DEPTH];
   rsp_item_type                   out_item;
   logic [OUT_PTR_BITS-1:0]        out_wr_ptr_ff;
   logic [OUT_PTR_BITS-1:0]        out_rd_ptr_ff;
   logic [OUT_CNT_BITS-1:0]        out_count_ff, out_count_in;
   logic [OUT_CNT_BITS:0]          out_occ;
   logic                           out_pop;

   ssws_ram #(.WIDTH(COL_SUM_BITS), .DEPTH(MAX_SIZE)) u_col_sums (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ff.col),
      .wr_data (col_sum_new),
      .rd_addr (q_item.col),
      .rd_data (col_sum_rd)
   );

   ssws_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(STORE_DEPTH)) u_row_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr ({s1_ff.row_slot, s1_ff.col}),
      .wr_data (s1_ff.element),
      .rd_addr ({q_item.old_slot, q_item.col}),
      .rd_data (row_store_rd)
   );

   assign out_pop = rsp_valid && !rsp_stall;
   assign s1_push = s1_valid_ff && s1_ff.emit;

   // Issue only when the result buffer has room for this item once it finishes
   assign out_occ = {1'b0, out_count_ff} + (OUT_CNT_BITS + 1)'(s1_push)
                    - (OUT_CNT_BITS + 1)'(out_pop);
   assign q_pop   = !q_empty && (out_occ < (OUT_CNT_BITS + 1)'(OUT_DEPTH));

   always_comb begin
      x_ext   = COL_SUM_BITS'(s1_ff.element);
      old_ext = COL_SUM_BITS'(signed'(row_store_rd));
      if (s1_ff.row_zero) begin
         col_sum_new = x_ext;
      end else if (s1_ff.row_ge_k) begin
         col_sum_new = signed'(col_sum_rd) + x_ext - old_ext;
      end else begin
         col_sum_new = signed'(col_sum_rd) + x_ext;
      end
      // Column sum that drops out of the window, taken from this row's tap line
      leaving = SUM_BITS'(tap_ff[s1_ff.tap_sel]);
      if (s1_ff.col_zero) begin
         run_in = SUM_BITS'(col_sum_new);
      end else if (s1_ff.col_ge_k) begin
         run_in = run_ff + SUM_BITS'(col_sum_new) - leaving;
      end else begin
         run_in = run_ff + SUM_BITS'(col_sum_new);
      end
      out_item.window_sum = run_in;
      out_item.row_done   = s1_ff.row_done;
      out_item.last       = s1_ff.last;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ff <= q_item;
      end
      if (s1_valid_ff) begin
         run_ff    <= run_in;
         tap_ff[0] <= col_sum_new;
         for (int i = 1; i < MAX_WINDOW; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
      if (s1_push) begin
         out_ff[out_wr_ptr_ff] <= out_item;
      end
   end

   assign out_count_in = out_count_ff + OUT_CNT_BITS'(s1_push) - OUT_CNT_BITS'(out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         s1_valid_ff  <= q_pop;
         out_count_ff <= out_count_in;
         if (s1_push) begin
            out_wr_ptr_ff <= out_wr_ptr_ff + OUT_PTR_BITS'(1);
         end
         if (out_pop) begin
            out_rd_ptr_ff <= out_rd_ptr_ff + OUT_PTR_BITS'(1);
         end
      end
   end

   assign rsp_valid      = (out_count_ff != '0);
   assign rsp_window_sum = out_ff[out_rd_ptr_ff].window_sum;
   assign rsp_row_done   = out_ff[out_rd_ptr_ff].row_done;
   assign rsp_last       = out_ff[out_rd_ptr_ff].last;

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      s1_push |-> (out_count_ff != OUT_CNT_BITS'(OUT_DEPTH) || out_pop))
      else $error("result written into a full buffer");

   a_issue_completes: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> s1_valid_ff) else $error("issued item lost before compute");

   a_last_is_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> rsp_row_done)
      else $error("final window not flagged as end of row");

endmodule

[sv/sub_square_window_sum.sv]
// Top level of the streaming k by k window sum block.
// Depends on ssws_pkg, ssws_front, ssws_queue, ssws_back, ssws_ram.
//
//   channel | ports                       | handshake      | carries
//   --------+-----------------------------+----------------+--------------------------------
//   req     | req_valid/req_stall         | valid & !stall | element_value (16b signed)
//   rsp     | rsp_valid/rsp_stall         | valid & !stall | window_sum (22b), row_done, last
//   csr     | csr_valid/csr_ready         | valid & ready  | csr_index, csr_data
//
// One element per cycle sustained while rsp_stall stays low; a sum passes the queue, the
// column-sum RAM read and the compute into the result buffer before it leaves.
// The rate is set by the single read/write port pair of each RAM, used once per element.
// Reset is synchronous; no clearing pass, stores are only read where already written.
// A stalled result side fills the two-entry result buffer, then the four-entry queue,
// then raises req_stall. A register write restarts the matrix at row 0, column 0.
module sub_square_window_sum import ssws_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [ELEMENT_BITS-1:0] req_element_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SUM_BITS-1:0]     rsp_window_sum,
   output logic                           rsp_row_done,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]       csr_data
);

   work_item_type push_item;
   work_item_type head;
   logic          push;
   logic          full;
   logic          pop;
   logic          empty;

   ssws_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .q_full            (full),
      .q_push            (push),
      .q_item            (push_item)
   );

   ssws_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   ssws_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (empty),
      .q_item         (head),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_window_sum (rsp_window_sum),
      .rsp_row_done   (rsp_row_done),
      .rsp_last       (rsp_last)
   );

endmodule

[sim/sub_square_window_sum_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sub_square_window_sum: streams matrices through the block
// and compares every k by k window sum, row_done and last against a local predictor.
// Depends on ssws_pkg and the sub_square_window_sum RTL.
module sub_square_window_sum_test;
   import ssws_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned DRAIN_LIMIT   = 5000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned RANDOM_ITEMS  = 100;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic signed [ELEMENT_BITS-1:0] CORNER_VALUES [0:4] =
      '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh5555};

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic signed [ELEMENT_BITS-1:0] req_element_value;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic signed [SUM_BITS-1:0]     rsp_window_sum;
   logic                           rsp_row_done;
   logic                           rsp_last;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [CSR_INDEX_BITS-1:0]      csr_index;
   logic [CSR_DATA_BITS-1:0]       csr_data;

   // Predictor state: geometry registers, element rows, column totals, running sum
   logic [MATRIX_SIZE_BITS-1:0]    side_reg;
   logic [WINDOW_SIZE_BITS-1:0]    window_reg;
   logic signed [ELEMENT_BITS-1:0] line_rows [0:MAX_WINDOW*MAX_SIZE-1];
   longint                         column_totals [0:MAX_SIZE-1];
   longint                         strip_total;
   int unsigned                    at_row;
   int unsigned                    at_col;

   rsp_item_type window_sums_due [$];

   int          fail_count  = 0;
   int unsigned cycle_count = 0;
   bit          idle_on     = 1'b1;
   bit          long_hold   = 1'b0;

   sub_square_window_sum DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_window_sum    (rsp_window_sum),
      .rsp_row_done      (rsp_row_done),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sub_square_window_sum_test: FAIL");
         $finish;
      end
   end

   function automatic int unsigned matrix_side();
      int unsigned n;
      n = 32'(side_reg);
      if (n < 1) n = 1;
      if (n > MAX_SIZE) n = MAX_SIZE;
      return n;
   endfunction

   function automatic bit predict_window_sum(input logic signed [ELEMENT_BITS-1:0] x,
                                             output rsp_item_type sum_out);
      int unsigned n, k, row, col, old_slot;
      bit produced;
      n = matrix_side();
      k = 32'(window_reg);
      if (k < 1) k = 1;
      if (k > MAX_WINDOW) k = MAX_WINDOW;
      row = at_row;
      col = at_col;
      if (row >= n) row = 0;
      if (col >= n) col = 0;

      // vertical: column total over the last k rows
      if (row == 0) begin
         column_totals[col] = longint'(x);
      end else if (row >= k) begin
         old_slot = ((row - k) % MAX_WINDOW) * MAX_SIZE + col;
         column_totals[col] = column_totals[col] + longint'(x)
                              - longint'(line_rows[old_slot]);
      end else begin
         column_totals[col] = column_totals[col] + longint'(x);
      end
      line_rows[(row % MAX_WINDOW) * MAX_SIZE + col] = x;

      // horizontal: running sum of the last k column totals
      if (col == 0) begin
         strip_total = column_totals[0];
      end else if (col >= k) begin
         strip_total = strip_total + column_totals[col] - column_totals[col - k];
      end else begin
         strip_total = strip_total + column_totals[col];
      end

      sum_out  = '0;
      produced = (k <= n) && (row + 1 >= k) && (col + 1 >= k);
      if (produced) begin
         sum_out.window_sum = SUM_BITS'(strip_total);
         sum_out.row_done   = (col == n - 1);
         sum_out.last       = (col == n - 1) && (row == n - 1);
      end

      col++;
      if (col >= n) begin
         col = 0;
         row++;
         if (row >= n) row = 0;
      end
      at_row = row;
      at_col = col;
      return produced;
   endfunction

   // Track register writes and accepted elements
   always @(posedge clock) begin
      rsp_item_type due;
      if (reset) begin
         side_reg    = MATRIX_SIZE_BITS'(MATRIX_SIZE_RESET);
         window_reg  = WINDOW_SIZE_BITS'(WINDOW_SIZE_RESET);
         at_row      = 0;
         at_col      = 0;
         strip_total = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MATRIX_SIZE: begin
                  side_reg    = csr_data[MATRIX_SIZE_BITS-1:0];
                  at_row      = 0;
                  at_col      = 0;
                  strip_total = 0;
               end
               CSR_WINDOW_SIZE: begin
                  window_reg  = csr_data[WINDOW_SIZE_BITS-1:0];
                  at_row      = 0;
                  at_col      = 0;
                  strip_total = 0;
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (predict_window_sum(req_element_value, due)) window_sums_due.push_back(due);
         end
      end
   end

   // Compare every result beat against the oldest expected sum
   always @(posedge clock) begin
      rsp_item_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (window_sums_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got sum %0d row_done %0b last %0b",
                     $time, rsp_window_sum, rsp_row_done, rsp_last);
            fail_count++;
         end else begin
            due = window_sums_due.pop_front();
            if (rsp_window_sum !== due.window_sum) begin
               $display("%0t: window_sum expected %0d, got %0d",
                        $time, due.window_sum, rsp_window_sum);
               fail_count++;
            end
            if (rsp_row_done !== due.row_done) begin
               $display("%0t: row_done expected %0b, got %0b",
                        $time, due.row_done, rsp_row_done);
               fail_count++;
            end
            if (rsp_last !== due.last) begin
               $display("%0t: last expected %0b, got %0b", $time, due.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Result side: random stall bursts, plus one long hold on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold  = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic signed [ELEMENT_BITS-1:0] random_element();
      if ($urandom_range(0, 3) == 0) return CORNER_VALUES[$urandom_range(0, 4)];
      return ELEMENT_BITS'($urandom_range(0, 65535));
   endfunction

   task automatic send_element(input logic signed [ELEMENT_BITS-1:0] value);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_element_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_matrix(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_element(random_element());
   endtask

   // Drop valid, wait for outstanding sums, then let the pipeline empty
   task automatic settle_block();
      int unsigned guard;
      guard      = 0;
      req_valid <= 1'b0;
      // let the predictor book the final beat first
      @(posedge clock);
      while (window_sums_due.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic pick_geometry(input int unsigned top_n);
      logic [CSR_DATA_BITS-1:0] n_data, k_data;
      n_data = CSR_DATA_BITS'($urandom_range(1, top_n));
      if ($urandom_range(0, 19) == 0) n_data = '0;
      k_data = CSR_DATA_BITS'($urandom_range(1, 8));
      if ($urandom_range(0, 9) == 0) k_data = CSR_DATA_BITS'($urandom_range(0, 127));
      case ($urandom_range(0, 3))
         0: write_reg(CSR_MATRIX_SIZE, n_data);
         1: write_reg(CSR_WINDOW_SIZE, k_data);
         2: begin
            write_reg(CSR_WINDOW_SIZE, k_data);
            write_reg(CSR_MATRIX_SIZE, n_data);
         end
         default: begin
            write_reg(CSR_MATRIX_SIZE, n_data);
            write_reg(CSR_WINDOW_SIZE, k_data);
         end
      endcase
   endtask

   // 5x5 matrix with a 3x3 window, straight out of reset
   task automatic test_default_geometry();
      for (int i = 0; i < 25; i++) send_element(CORNER_VALUES[i % 5]);
   endtask

   // Single 8x8 window of all-maximum, then all-minimum elements
   task automatic test_full_scale_sums();
      write_reg(CSR_MATRIX_SIZE, 7'd8);
      write_reg(CSR_WINDOW_SIZE, 7'd8);
      repeat (64) send_element(CORNER_VALUES[0]);
      repeat (64) send_element(CORNER_VALUES[1]);
   endtask

   // Window wider than the matrix gives nothing; 1x1 flags every beat
   task automatic test_oversized_window();
      write_reg(CSR_MATRIX_SIZE, 7'd3);
      write_reg(CSR_WINDOW_SIZE, 7'd4);
      send_matrix(12);
      write_reg(CSR_MATRIX_SIZE, 7'd1);
      write_reg(CSR_WINDOW_SIZE, 7'd1);
      send_matrix(3);
   endtask

   // Zero sizes read as one, oversized ones clamp to the maximum
   task automatic test_clamped_sizes();
      write_reg(CSR_MATRIX_SIZE, 7'd0);
      write_reg(CSR_WINDOW_SIZE, 7'd0);
      send_matrix(3);
      write_reg(CSR_MATRIX_SIZE, 7'h7f);
      write_reg(CSR_WINDOW_SIZE, 7'h7f);
      send_matrix(9 * MAX_SIZE);
   endtask

   // Spare indexes leave the matrix position alone; real writes restart it
   task automatic test_spare_index_and_restart();
      write_reg(CSR_MATRIX_SIZE, 7'd4);
      write_reg(CSR_WINDOW_SIZE, 7'h12);
      send_matrix(6);
      write_reg(CSR_SPARE_LO, 7'h7f);
      send_matrix(10);
      send_matrix(5);
      write_reg(CSR_SPARE_HI, 7'h55);
      write_reg(CSR_WINDOW_SIZE, 7'd2);
      send_matrix(16);
   endtask

   // Hold the result side long enough to back the block up into req_stall
   task automatic test_backpressure();
      write_reg(CSR_MATRIX_SIZE, 7'd6);
      write_reg(CSR_WINDOW_SIZE, 7'd1);
      idle_on   = 1'b0;
      long_hold = 1'b1;
      send_matrix(72);
      idle_on   = 1'b1;
   endtask

   task automatic test_random_geometry();
      int unsigned sent, count;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick_geometry(($urandom_range(0, 9) == 0) ? 20 : 10);
         repeat ($urandom_range(1, 3)) begin
            count = matrix_side() * matrix_side();
            // broken matrix: stop part way through
            if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
            send_matrix(count);
            sent += count;
         end
      end
   endtask

   // Last stretch at full rate on both sides
   task automatic test_quiet_tail();
      idle_on = 1'b0;
      pick_geometry(8);
      send_matrix(3 * matrix_side() * matrix_side());
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_element_value <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= CSR_MATRIX_SIZE;
      csr_data          <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_geometry();
      test_full_scale_sums();
      test_oversized_window();
      test_clamped_sizes();
      test_spare_index_and_restart();
      test_backpressure();
      test_random_geometry();
      test_quiet_tail();

      settle_block();
      if (window_sums_due.size() != 0) begin
         $display("%0t: %0d expected sums never arrived, first expected %0d",
                  $time, window_sums_due.size(), window_sums_due[0].window_sum);
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("sub_square_window_sum_test: PASS");
      end else begin
         $display("sub_square_window_sum_test: FAIL");
      end
      $finish;
   end

endmodule
